// ===== hw/rtl/ptb_pkg.sv =====
// ----------------------------------------------------------------------------
// ptb_pkg
// Shared types and codes of the periodic timer bank: request and result
// items, request and result codes, sweep state encoding.
// ----------------------------------------------------------------------------
package ptb_pkg;

  // request codes
  localparam logic [1:0] REQ_TICK   = 2'd0;
  localparam logic [1:0] REQ_ADD    = 2'd1;
  localparam logic [1:0] REQ_DELETE = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // result codes
  localparam logic [1:0] KIND_FIRE    = 2'd0;
  localparam logic [1:0] KIND_ADDED   = 2'd1;
  localparam logic [1:0] KIND_FULL    = 2'd2;
  localparam logic [1:0] KIND_DELETED = 2'd3;

  // most fire items reported for one tick
  localparam int MAX_FIRE = 16;
  localparam int FIRE_W   = $clog2(MAX_FIRE + 1);

  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  slot;
    logic [15:0] period;
    logic [7:0]  target;
    logic [31:0] message;
    logic [31:0] payload;
    logic [7:0]  owner_group;
    logic        start_stopped;
    logic        parent_only;
    logic [7:0]  current_group;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  slot_out;
    logic [7:0]  target_out;
    logic [31:0] message_out;
    logic [31:0] payload_out;
    logic        last;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_FLUSH
  } state_t;

endpackage

// ===== hw/rtl/periodic_timer_bank_unit.sv =====
// ----------------------------------------------------------------------------
// periodic_timer_bank_unit
// Table of periodic timer slots kept in one RAM, swept once per tick.
// ----------------------------------------------------------------------------
// Requests arrive on the in_ channel (valid/ready), results leave on the out_
// channel (valid/ready), one registered output item.
// Add: claims the lowest free slot, answers added or table full; one result,
//   visible the cycle after the request is taken. Delete frees the named slot
//   and answers deleted. Request type 3 is dropped without a result.
// Tick: the RAM is swept one slot per cycle while no stalled receiver holds
//   the sweep, the read of slot i overlapping the count update of slot i-1;
//   a stalled receiver also holds the flush of the final item, and in_ready
//   stays low for the whole tick. Fire items come out in ascending slot
//   order; the final one carries last, and one fire item is held back until
//   the next one (or the end of the sweep) is known.
//   A tick with no firings gives no item.
// in_ready is high only between requests while the output register is free
// or being emptied, so one request is in work at a time; adds and deletes
// never leave the idle state.
// A stalled receiver holds the sweep at the next reportable firing.
// Reset frees every slot; the RAM itself is not cleared and needs no pass.
// ----------------------------------------------------------------------------
module periodic_timer_bank_unit #(
  parameter int NUM_SLOTS   = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ptb_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ptb_pkg::out_item_t out_data
);

  import ptb_pkg::*;

  localparam int SLOT_W = $clog2(NUM_SLOTS);

  typedef struct packed {
    logic [COUNT_WIDTH-1:0] cnt;
    logic [COUNT_WIDTH-1:0] period;
    logic [7:0]             target;
    logic [31:0]            message;
    logic [31:0]            payload;
    logic [7:0]             group;
    logic                   parent;
    logic                   stopped;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  state_t              state_r, state_nxt;
  logic [NUM_SLOTS-1:0] slot_valid_r, slot_valid_nxt;
  logic [SLOT_W:0]     rd_idx_r, rd_idx_nxt;
  logic [SLOT_W-1:0]   ev_idx_r, ev_idx_nxt;
  logic                ev_vld_r, ev_vld_nxt;
  logic [FIRE_W-1:0]   fire_n_r, fire_n_nxt;
  logic [7:0]          cur_grp_r, cur_grp_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r, out_data_nxt;
  logic                pend_vld_r, pend_vld_nxt;
  out_item_t           pend_r, pend_nxt;

  logic                ram_we;
  logic [SLOT_W-1:0]   ram_waddr;
  rec_t                ram_wdata;
  logic                ram_re;
  logic [SLOT_W-1:0]   ram_raddr;
  rec_t                ram_rdata;

  logic                in_fire;
  logic                out_free;
  logic                rd_done;
  logic                any_free;
  logic [SLOT_W-1:0]   free_idx;
  logic                active;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic                hit;
  logic                report;
  logic                stall;
  out_item_t           fire_item;

  ptb_ram #(
    .WIDTH (REC_W),
    .DEPTH (NUM_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE) && out_free;
  assign in_fire   = in_valid && in_ready;
  assign rd_done   = (rd_idx_r == (SLOT_W + 1)'(NUM_SLOTS));
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // lowest free slot
  always_comb begin
    any_free = 1'b0;
    free_idx = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!slot_valid_r[i]) begin
        any_free = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
  end

  // evaluation of the slot whose record sits on the RAM output
  assign active  = ev_vld_r && slot_valid_r[ev_idx_r] && !ram_rdata.stopped;
  assign cnt_inc = ram_rdata.cnt + COUNT_WIDTH'(1);
  assign hit     = (cnt_inc == ram_rdata.period);
  assign report  = active && hit &&
                   (!ram_rdata.parent || (ram_rdata.group == cur_grp_r)) &&
                   (fire_n_r < FIRE_W'(MAX_FIRE));
  // a second firing can only move on when the held one can go out
  assign stall   = report && pend_vld_r && !out_free;

  always_comb begin
    fire_item             = '0;
    fire_item.kind        = KIND_FIRE;
    fire_item.slot_out    = 4'(ev_idx_r);
    fire_item.target_out  = ram_rdata.target;
    fire_item.message_out = ram_rdata.message;
    fire_item.payload_out = ram_rdata.payload;
    fire_item.last        = 1'b0;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_data.req_type == REQ_TICK)) begin
          state_nxt = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (!ev_vld_r && rd_done) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!pend_vld_r || out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    slot_valid_nxt = slot_valid_r;
    rd_idx_nxt     = rd_idx_r;
    ev_idx_nxt     = ev_idx_r;
    ev_vld_nxt     = ev_vld_r;
    fire_n_nxt     = fire_n_r;
    cur_grp_nxt    = cur_grp_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    pend_vld_nxt   = pend_vld_r;
    pend_nxt       = pend_r;
    ram_we         = 1'b0;
    ram_waddr      = ev_idx_r;
    ram_wdata      = ram_rdata;
    ram_re         = 1'b0;
    ram_raddr      = rd_idx_r[SLOT_W-1:0];

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          out_data_nxt      = '0;
          out_data_nxt.last = 1'b1;
          case (in_data.req_type)
            REQ_ADD: begin
              out_valid_nxt = 1'b1;
              if (any_free) begin
                ram_we                 = 1'b1;
                ram_waddr              = free_idx;
                ram_wdata.cnt          = '0;
                ram_wdata.period       = COUNT_WIDTH'(in_data.period);
                ram_wdata.target       = in_data.target;
                ram_wdata.message      = in_data.message;
                ram_wdata.payload      = in_data.payload;
                ram_wdata.group        = in_data.owner_group;
                ram_wdata.parent       = in_data.parent_only;
                ram_wdata.stopped      = in_data.start_stopped;
                slot_valid_nxt[free_idx] = 1'b1;
                out_data_nxt.kind      = KIND_ADDED;
                out_data_nxt.slot_out  = 4'(free_idx);
              end else begin
                out_data_nxt.kind      = KIND_FULL;
              end
            end
            REQ_DELETE: begin
              out_valid_nxt         = 1'b1;
              out_data_nxt.kind     = KIND_DELETED;
              out_data_nxt.slot_out = in_data.slot;
              if (32'(in_data.slot) < NUM_SLOTS) begin
                slot_valid_nxt[SLOT_W'(in_data.slot)] = 1'b0;
              end
            end
            REQ_TICK: begin
              rd_idx_nxt  = '0;
              ev_vld_nxt  = 1'b0;
              fire_n_nxt  = '0;
              cur_grp_nxt = in_data.current_group;
            end
            REQ_UNUSED: begin
              out_data_nxt = out_data_r;
            end
            default: begin
              out_data_nxt = out_data_r;
            end
          endcase
        end
      end
      ST_SWEEP: begin
        if (!stall) begin
          if (active) begin
            ram_we        = 1'b1;
            ram_wdata.cnt = hit ? '0 : cnt_inc;
          end
          if (report) begin
            fire_n_nxt   = fire_n_r + FIRE_W'(1);
            pend_vld_nxt = 1'b1;
            pend_nxt     = fire_item;
            if (pend_vld_r) begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = pend_r;
            end
          end
          if (!rd_done) begin
            ram_re     = 1'b1;
            ev_vld_nxt = 1'b1;
            ev_idx_nxt = rd_idx_r[SLOT_W-1:0];
            rd_idx_nxt = rd_idx_r + (SLOT_W + 1)'(1);
          end else begin
            ev_vld_nxt = 1'b0;
          end
        end
      end
      ST_FLUSH: begin
        if (pend_vld_r && out_free) begin
          out_valid_nxt     = 1'b1;
          out_data_nxt      = pend_r;
          out_data_nxt.last = 1'b1;
          pend_vld_nxt      = 1'b0;
        end
      end
      default: begin
        pend_vld_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      slot_valid_r <= '0;
      rd_idx_r     <= '0;
      ev_vld_r     <= 1'b0;
      fire_n_r     <= '0;
      out_valid_r  <= 1'b0;
      pend_vld_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      slot_valid_r <= slot_valid_nxt;
      rd_idx_r     <= rd_idx_nxt;
      ev_vld_r     <= ev_vld_nxt;
      fire_n_r     <= fire_n_nxt;
      out_valid_r  <= out_valid_nxt;
      pend_vld_r   <= pend_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ev_idx_r   <= ev_idx_nxt;
    cur_grp_r  <= cur_grp_nxt;
    out_data_r <= out_data_nxt;
    pend_r     <= pend_nxt;
  end

  // a held fire item only exists inside a tick
  a_pend_in_tick: assert property (@(posedge clk) disable iff (!rst_n)
    pend_vld_r |-> (state_r == ST_SWEEP || state_r == ST_FLUSH))
    else $error("held fire item outside a tick");

  // the write-back never hits the entry being read
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("read and write of the same slot in one cycle");

  a_fire_limit: assert property (@(posedge clk) disable iff (!rst_n)
    fire_n_r <= FIRE_W'(MAX_FIRE))
    else $error("fire count beyond limit");

  // flushing a held item ends the tick with last set
  a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH && pend_vld_r && out_free) |=>
      (out_valid_r && out_data_r.last && state_r == ST_IDLE))
    else $error("tick ended without a last item");

  // no new request while the sweep is running
  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWEEP) |-> !in_ready)
    else $error("request taken during a sweep");

endmodule

// ===== hw/rtl/ptb_ram.sv =====
// ----------------------------------------------------------------------------
// ptb_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module ptb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
